// ===== design/okl_pkg.sv =====
// Shared types and constants for the Oklab color converter.
// Holds the matrix coefficients, the fixed-point format and the pipeline depths.
// Used by okl_dot, okl_nonlin and oklab_color_converter.
package okl_pkg;

   // Fixed-point format of every component.
   localparam int FRAC_BITS = 16;
   localparam int FIELD_W   = 19;
   localparam int MID_W     = 28;
   localparam int RES_W     = 32;

   localparam logic signed [FIELD_W-1:0] OUT_MAX = 19'sd262143;
   localparam logic signed [FIELD_W-1:0] OUT_MIN = -19'sd262144;

   // Coefficients are integers scaled by ten to the tenth.
   typedef logic signed [36:0] coef_type;

   typedef struct packed {
      coef_type c0;
      coef_type c1;
      coef_type c2;
   } coef_row_type;

   localparam coef_row_type RGB_LMS [3] = '{
      '{37'sd4122214708, 37'sd5363325363, 37'sd514459929},
      '{37'sd2119034982, 37'sd6806995451, 37'sd1073969566},
      '{37'sd883024619,  37'sd2817188376, 37'sd6299787005}
   };
   localparam coef_row_type LMS_LAB [3] = '{
      '{37'sd2104542553,  37'sd7936177850,   -37'sd40720468},
      '{37'sd19779984951, -37'sd24285922050, 37'sd4505937099},
      '{37'sd259040371,   37'sd7827717662,   -37'sd8086757660}
   };
   localparam coef_row_type LAB_LMS [3] = '{
      '{37'sd10000000000, 37'sd3963377774,  37'sd2158037573},
      '{37'sd10000000000, -37'sd1055613458, -37'sd638541728},
      '{37'sd10000000000, -37'sd894841775,  -37'sd12914855480}
   };
   localparam coef_row_type LMS_RGB [3] = '{
      '{37'sd40767416621,  -37'sd33077115913, 37'sd2309699292},
      '{-37'sd12684380046, 37'sd26097574011,  -37'sd3413193965},
      '{-37'sd41960863,    -37'sd7034186147,  37'sd17076147010}
   };

   // Rounding to nearest after the dot product: add half of ten to the tenth,
   // drop ten bits, then divide by five to the tenth.
   localparam logic signed [65:0] HALF_DEC = 66'sd5000000000;
   localparam logic [23:0] DIV5    = 24'd9765625;
   // Offset that keeps the dividend positive; the quotient offset is 2^30.
   localparam logic [53:0] KB_OFS  = 54'd10485760000000000;
   localparam logic signed [RES_W-1:0] Q_OFS = 32'sd1073741824;
   // floor(2^54 / 5^10)
   localparam logic [30:0] RECIP   = 31'd1844674407;

   // Pipeline depths.
   localparam int DOT_LAT    = 7;
   localparam int CBRT_STEPS = 17;
   localparam int NL_LAT     = CBRT_STEPS + 2;
   localparam int TOTAL_LAT  = 2 * DOT_LAT + NL_LAT + 1;

endpackage

// ===== design/oklab_color_converter.sv =====
// Top level of the linear RGB / Oklab converter: three lanes of matrix row,
// nonlinearity and matrix row, merged into one saturated result item.
// Depends on okl_pkg, okl_dot and okl_nonlin.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. busy is
//   low except during reset, so one item can be taken every clock cycle.
//   Each item yields one result item, marked by rsp_valid for one cycle;
//   items leave in the order they came.
//   The depth is set by the two seven-stage dot product and rounding
//   pipelines, the 19-stage nonlinearity (one setup stage, 17 cube root
//   stages and one select stage) and one output stage.
//   The receiver cannot stall, so results are never held back.
//   csr_write_enable writes csr_write_data into the direction register:
//   0 converts linear RGB to Oklab, 1 converts Oklab to linear RGB. Each item
//   uses the direction in force when it was taken.
//   Reset (synchronous, active high) clears the direction to zero and drops
//   every item in flight.
//   rsp_saturated is set when any of the three result components was clamped.
module oklab_color_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [okl_pkg::FIELD_W-1:0] req_comp_0,
   input  logic signed [okl_pkg::FIELD_W-1:0] req_comp_1,
   input  logic signed [okl_pkg::FIELD_W-1:0] req_comp_2,
   output logic                               rsp_valid,
   output logic signed [okl_pkg::FIELD_W-1:0] rsp_out_0,
   output logic signed [okl_pkg::FIELD_W-1:0] rsp_out_1,
   output logic signed [okl_pkg::FIELD_W-1:0] rsp_out_2,
   output logic                               rsp_saturated,
   input  logic                               csr_write_enable,
   input  logic [0:0]                         csr_write_data
);

   localparam int LAT     = okl_pkg::TOTAL_LAT;
   localparam int SEL_TAP = okl_pkg::DOT_LAT + okl_pkg::NL_LAT - 2;
   localparam int RW2_TAP = okl_pkg::DOT_LAT + okl_pkg::NL_LAT - 1;

   logic direction_ff;
   logic vld_ff [LAT];
   logic dir_ff [LAT];

   logic signed [okl_pkg::MID_W-1:0] vin [3];
   okl_pkg::coef_row_type            row1 [3];
   okl_pkg::coef_row_type            row2 [3];
   logic signed [okl_pkg::RES_W-1:0] d1_res [3];
   logic signed [okl_pkg::MID_W-1:0] mid [3];
   logic signed [okl_pkg::RES_W-1:0] d2_res [3];

   logic signed [okl_pkg::FIELD_W-1:0] out_in [3];
   logic signed [okl_pkg::FIELD_W-1:0] out_ff [3];
   logic                               sat_in, sat_ff;

   assign busy = reset;

   // Direction register.
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
      end else if (csr_write_enable) begin
         direction_ff <= csr_write_data[0];
      end
   end

   // Item tracking: valid and direction travel beside the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
            dir_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start & ~busy;
         dir_ff[0] <= direction_ff;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
            dir_ff[k] <= dir_ff[k-1];
         end
      end
   end

   assign vin[0] = okl_pkg::MID_W'(req_comp_0);
   assign vin[1] = okl_pkg::MID_W'(req_comp_1);
   assign vin[2] = okl_pkg::MID_W'(req_comp_2);

   // Three lanes, one per component.
   for (genvar g = 0; g < 3; g++) begin : g_lane
      assign row1[g] = direction_ff ? okl_pkg::LAB_LMS[g] : okl_pkg::RGB_LMS[g];
      assign row2[g] = dir_ff[RW2_TAP] ? okl_pkg::LMS_RGB[g] : okl_pkg::LMS_LAB[g];

      okl_dot u_dot1 (
         .clock (clock),
         .coef  (row1[g]),
         .v0    (vin[0]),
         .v1    (vin[1]),
         .v2    (vin[2]),
         .res   (d1_res[g])
      );

      okl_nonlin u_nonlin (
         .clock (clock),
         .dir   (dir_ff[SEL_TAP]),
         .x     (d1_res[g]),
         .mid   (mid[g])
      );

      okl_dot u_dot2 (
         .clock (clock),
         .coef  (row2[g]),
         .v0    (mid[0]),
         .v1    (mid[1]),
         .v2    (mid[2]),
         .res   (d2_res[g])
      );
   end

   // Merge: clamp each lane and collect the saturation flag.
   always_comb begin
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (d2_res[k] > okl_pkg::RES_W'(okl_pkg::OUT_MAX)) begin
            out_in[k] = okl_pkg::OUT_MAX;
            sat_in    = 1'b1;
         end else if (d2_res[k] < okl_pkg::RES_W'(okl_pkg::OUT_MIN)) begin
            out_in[k] = okl_pkg::OUT_MIN;
            sat_in    = 1'b1;
         end else begin
            out_in[k] = d2_res[k][okl_pkg::FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         out_ff[k] <= out_in[k];
      end
      sat_ff <= sat_in;
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_out_0     = out_ff[0];
   assign rsp_out_1     = out_ff[1];
   assign rsp_out_2     = out_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

// ===== design/okl_dot.sv =====
// One matrix row: exact dot product of three components with scaled coefficients,
// then division by ten to the tenth, rounded to nearest. Seven pipeline stages.
// Depends on okl_pkg.
module okl_dot (
   input  logic                                clock,
   input  okl_pkg::coef_row_type               coef,
   input  logic signed [okl_pkg::MID_W-1:0]    v0,
   input  logic signed [okl_pkg::MID_W-1:0]    v1,
   input  logic signed [okl_pkg::MID_W-1:0]    v2,
   output logic signed [okl_pkg::RES_W-1:0]    res
);

   okl_pkg::coef_type                c_arr [3];
   logic signed [okl_pkg::MID_W-1:0] v_arr [3];

   logic signed [46:0] ph_ff [3];
   logic signed [46:0] pl_ff [3];
   logic signed [65:0] s_in, s_ff;
   logic signed [55:0] u_in;
   logic [53:0]        n_in, n_ff, n_d_ff, n_e_ff, n_f_ff;
   logic [62:0]        plo_ff;
   logic [52:0]        phi_ff;
   logic [84:0]        p_in;
   logic [30:0]        qe_ff, qe_f_ff;
   logic [54:0]        qd_ff;
   logic [53:0]        r_in;
   logic [30:0]        q_in;
   logic signed [okl_pkg::RES_W-1:0] res_in, res_ff;

   always_comb begin
      c_arr[0] = coef.c0;
      c_arr[1] = coef.c1;
      c_arr[2] = coef.c2;
      v_arr[0] = v0;
      v_arr[1] = v1;
      v_arr[2] = v2;
   end

   // Split each coefficient at bit 18 so each product stays narrow.
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ph_ff[k] <= v_arr[k] * $signed(c_arr[k][36:18]);
         pl_ff[k] <= v_arr[k] * $signed({1'b0, c_arr[k][17:0]});
      end
   end

   // Exact sum plus the rounding half.
   always_comb begin
      s_in = ((66'(ph_ff[0]) + 66'(ph_ff[1]) + 66'(ph_ff[2])) <<< 18)
             + 66'(pl_ff[0]) + 66'(pl_ff[1]) + 66'(pl_ff[2]) + okl_pkg::HALF_DEC;
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   // Drop the power-of-two part of the divisor and offset to a positive dividend.
   always_comb begin
      u_in = 56'(s_ff >>> 10);
      n_in = 54'(u_in) + okl_pkg::KB_OFS;
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
   end

   // Reciprocal multiplication in two partial products.
   always_ff @(posedge clock) begin
      plo_ff <= 63'(n_ff[31:0]) * 63'(okl_pkg::RECIP);
      phi_ff <= 53'(n_ff[53:32]) * 53'(okl_pkg::RECIP);
      n_d_ff <= n_ff;
   end

   always_comb begin
      p_in = (85'(phi_ff) << 32) + 85'(plo_ff);
   end

   always_ff @(posedge clock) begin
      qe_ff  <= p_in[84:54];
      n_e_ff <= n_d_ff;
   end

   // Back-multiply the estimate to find the remainder.
   always_ff @(posedge clock) begin
      qd_ff   <= 55'(qe_ff) * 55'(okl_pkg::DIV5);
      qe_f_ff <= qe_ff;
      n_f_ff  <= n_e_ff;
   end

   // The estimate is low by at most one.
   always_comb begin
      r_in   = n_f_ff - qd_ff[53:0];
      q_in   = qe_f_ff + 31'(r_in >= 54'(okl_pkg::DIV5));
      res_in = $signed({1'b0, q_in}) - okl_pkg::Q_OFS;
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

// ===== design/okl_nonlin.sv =====
// Per-component nonlinearity: a pipelined signed cube root for the forward
// direction and a fixed-point cube for the inverse, selected at the output.
// Depends on okl_pkg.
module okl_nonlin (
   input  logic                             clock,
   input  logic                             dir,
   input  logic signed [okl_pkg::RES_W-1:0] x,
   output logic signed [okl_pkg::MID_W-1:0] mid
);

   localparam int STEPS  = okl_pkg::CBRT_STEPS;
   localparam int SH     = 2 * okl_pkg::FRAC_BITS;
   localparam int MAG_W  = 20;
   localparam int REM_W  = MAG_W + SH;
   localparam int SQ_W   = 2 * STEPS;
   localparam int D_W    = REM_W + 4;
   localparam int CUBE_DLY = STEPS + 1 - 3;

   logic [MAG_W-1:0]  mag_in;
   logic [REM_W-1:0]  rem_ff  [STEPS+1];
   logic [STEPS-1:0]  root_ff [STEPS+1];
   logic [SQ_W-1:0]   sq_ff   [STEPS+1];
   logic              neg_ff  [STEPS+1];
   logic signed [okl_pkg::MID_W-1:0] cbrt_in;

   logic signed [20:0] xs;
   logic [39:0]        x2_ff;
   logic signed [20:0] xc_ff;
   logic signed [41:0] ch_ff, cl_ff;
   logic signed [61:0] cs_in;
   logic signed [okl_pkg::MID_W-1:0] cube_ff [CUBE_DLY+1];
   logic signed [okl_pkg::MID_W-1:0] mid_in, mid_ff;

   // Cube root setup: magnitude scaled by two fraction widths.
   always_comb begin
      mag_in = x[okl_pkg::RES_W-1] ? MAG_W'(-x) : MAG_W'(x);
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= {mag_in, SH'(0)};
      root_ff[0] <= '0;
      sq_ff[0]   <= '0;
      neg_ff[0]  <= x[okl_pkg::RES_W-1];
   end

   // One root bit per stage, tracking the remainder and the root squared.
   for (genvar i = 1; i <= STEPS; i++) begin : g_step
      localparam int B = STEPS - i;
      logic [D_W-1:0] d_in;
      logic           take_in;

      always_comb begin
         d_in = ((D_W'(sq_ff[i-1]) + (D_W'(sq_ff[i-1]) << 1)) << B)
                + ((D_W'(root_ff[i-1]) + (D_W'(root_ff[i-1]) << 1)) << (2 * B))
                + (D_W'(1) << (3 * B));
         take_in = d_in <= D_W'(rem_ff[i-1]);
      end

      always_ff @(posedge clock) begin
         neg_ff[i] <= neg_ff[i-1];
         if (take_in) begin
            rem_ff[i]  <= rem_ff[i-1] - REM_W'(d_in);
            sq_ff[i]   <= sq_ff[i-1] + (SQ_W'(root_ff[i-1]) << (B + 1)) + (SQ_W'(1) << (2 * B));
            root_ff[i] <= root_ff[i-1] | (STEPS'(1) << B);
         end else begin
            rem_ff[i]  <= rem_ff[i-1];
            sq_ff[i]   <= sq_ff[i-1];
            root_ff[i] <= root_ff[i-1];
         end
      end
   end

   always_comb begin
      cbrt_in = neg_ff[STEPS] ? -okl_pkg::MID_W'(root_ff[STEPS])
                              : okl_pkg::MID_W'(root_ff[STEPS]);
   end

   // Cube: square, then two partial products, then round and rescale.
   assign xs = x[20:0];

   always_ff @(posedge clock) begin
      x2_ff <= 40'(xs * xs);
      xc_ff <= xs;
      ch_ff <= $signed({1'b0, x2_ff[39:20]}) * xc_ff;
      cl_ff <= $signed({1'b0, x2_ff[19:0]}) * xc_ff;
   end

   always_comb begin
      cs_in = (62'(ch_ff) <<< 20) + 62'(cl_ff) + (62'sd1 <<< (SH - 1));
   end

   // Delay the cube to line up with the cube root.
   always_ff @(posedge clock) begin
      cube_ff[0] <= cs_in[SH + okl_pkg::MID_W - 1:SH];
      for (int k = 1; k <= CUBE_DLY; k++) begin
         cube_ff[k] <= cube_ff[k-1];
      end
   end

   always_comb begin
      mid_in = dir ? cube_ff[CUBE_DLY] : cbrt_in;
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

   assign mid = mid_ff;

endmodule
